>>> hw/rtl/irtok_pkg.sv
`default_nettype none

package irtok_pkg;

   // Spans leave the block at this fixed width, whatever the internal position width.
   localparam int SPAN_BITS = 24;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_LOWER_E   = 8'h65;
   localparam logic [7:0] CH_UPPER_E   = 8'h45;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [0:0] {
      FUNC_BYTE = 1'b0,
      FUNC_END  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      KIND_ARROW   = 3'd0,
      KIND_STRING  = 3'd1,
      KIND_PERCENT = 3'd2,
      KIND_AT      = 3'd3,
      KIND_IDENT   = 3'd4,
      KIND_NUMBER  = 3'd5,
      KIND_PUNCT   = 3'd6,
      KIND_END     = 3'd7
   } token_kind_type;

   typedef enum logic [1:0] {
      DIAG_UNTERM     = 2'd0,
      DIAG_NONAME     = 2'd1,
      DIAG_UNEXPECTED = 2'd2
   } diag_code_type;

   typedef struct packed {
      logic                 is_diag;
      token_kind_type       kind;
      diag_code_type        code;
      logic [SPAN_BITS-1:0] span_begin;
      logic [SPAN_BITS-1:0] span_end;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE) || (c == CH_DOT);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D) ||
             (c == 8'h28) || (c == 8'h29) || (c == 8'h3A) || (c == 8'h2C) ||
             (c == 8'h3D);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ir_text_tokenizer_core.sv
`default_nettype none
// Streaming tokenizer for a textual IR.
// Request channel (req_valid / req_stall): one source byte per request, or an
// end-of-source marker (req_func = 1). Response channel (rsp_valid / rsp_stall):
// token or diagnostic records with begin/end byte positions; rsp_last_of_run
// marks the final record caused by one request. A request may cause zero to
// three records.
// A taken request waits in the request register until its first record moves
// into the response register. Throughput: one request per cycle while rsp is
// not stalled; a request causing several records holds the request register
// until all are loaded, as the single response register takes one record per
// cycle. Requests that cause no record (most bytes) retire without waiting on rsp.
// A request is taken while the previous one retires, and the response register
// reloads in the same cycle its record is taken, so both sides run back to back.
// A stalled response holds its record and, once the request register holds a
// record-bearing request, req_stall rises until the response side drains.
// Synchronous reset clears the lexer to idle between tokens, position zero,
// and empties both registers. After an end-of-source request the lexer
// returns to that same state, ready for a new source.
module ir_text_tokenizer_core #(
   parameter int POSITION_BITS = 24
) (
   input  wire  logic                             clock,
   input  wire  logic                             reset,
   input  wire  logic                             req_valid,
   output       logic                             req_stall,
   input  wire  logic                             req_func,
   input  wire  logic [7:0]                       req_byte_value,
   output       logic                             rsp_valid,
   input  wire  logic                             rsp_stall,
   output       logic                             rsp_is_diagnostic,
   output       logic [2:0]                       rsp_token_kind,
   output       logic [1:0]                       rsp_diag_code,
   output       logic [irtok_pkg::SPAN_BITS-1:0]  rsp_span_begin,
   output       logic [irtok_pkg::SPAN_BITS-1:0]  rsp_span_end,
   output       logic                             rsp_last_of_run
);
   import irtok_pkg::*;

   localparam int ExtBits = (POSITION_BITS > SPAN_BITS) ? POSITION_BITS : SPAN_BITS;
   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_SLASH    = 4'd1,
      MODE_COMMENT  = 4'd2,
      MODE_MINUS    = 4'd3,
      MODE_STRING   = 4'd4,
      MODE_STR_ESC  = 4'd5,
      MODE_SIGIL    = 4'd6,
      MODE_NAME     = 4'd7,
      MODE_IDENT    = 4'd8,
      MODE_NUM_INT  = 4'd9,
      MODE_NUM_FRAC = 4'd10,
      MODE_NUM_E    = 4'd11,
      MODE_NUM_EXP  = 4'd12
   } lex_mode_type;

   // Saturating position increment.
   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
      return (x == PosMax) ? x : x + POSITION_BITS'(1);
   endfunction

   // Narrow or widen a position to the output span width.
   function automatic logic [SPAN_BITS-1:0] to_span(input logic [POSITION_BITS-1:0] x);
      logic [ExtBits-1:0] w;
      w = ExtBits'(x);
      return w[SPAN_BITS-1:0];
   endfunction

   function automatic result_type mk_tok(input token_kind_type k,
                                         input logic [POSITION_BITS-1:0] b,
                                         input logic [POSITION_BITS-1:0] e);
      result_type r;
      r.is_diag    = 1'b0;
      r.kind       = k;
      r.code       = DIAG_UNTERM;
      r.span_begin = to_span(b);
      r.span_end   = to_span(e);
      return r;
   endfunction

   function automatic result_type mk_diag(input diag_code_type d,
                                          input logic [POSITION_BITS-1:0] b,
                                          input logic [POSITION_BITS-1:0] e);
      result_type r;
      r.is_diag    = 1'b1;
      r.kind       = KIND_ARROW;
      r.code       = d;
      r.span_begin = to_span(b);
      r.span_end   = to_span(e);
      return r;
   endfunction

   // Request register, sub-record index and lexer state.
   logic                     in_valid_ff;
   logic                     in_func_ff;
   logic [7:0]               in_byte_ff;
   logic [1:0]               idx_ff, idx_in;
   lex_mode_type             mode_ff, mode_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     sigil_ff, sigil_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_rec_ff;
   logic                     rsp_last_ff;

   // Per-request decode.
   result_type               pre_rec [2];
   logic [1:0]               pre_cnt;
   result_type               post_rec;
   logic                     post_valid;
   logic [1:0]               rec_cnt;
   result_type               sel_rec;
   logic                     sel_last;
   logic                     out_free;
   logic                     emit_now;
   logic                     retire;
   logic                     accept;
   token_kind_type           sigil_kind;

   // Step logic: what the previous mode closes (pre records), then how a
   // byte is taken up fresh from idle (post record), or the end token.
   always_comb begin
      logic [7:0]               c;
      logic [POSITION_BITS-1:0] p;
      logic [POSITION_BITS-1:0] s;
      logic                     redo;
      lex_mode_type             step_mode;
      logic                     idle_emit;
      result_type               idle_rec;
      lex_mode_type             idle_mode;
      logic [POSITION_BITS-1:0] idle_start;
      logic                     idle_sigil;

      c          = in_byte_ff;
      p          = pos_ff;
      s          = start_ff;
      sigil_kind = sigil_ff ? KIND_PERCENT : KIND_AT;
      pre_rec[0] = '0;
      pre_rec[1] = '0;
      pre_cnt    = 2'd0;
      redo       = 1'b0;
      step_mode  = mode_ff;

      // Fresh byte from idle.
      idle_emit  = 1'b0;
      idle_rec   = mk_tok(KIND_PUNCT, p, sat_inc(p));
      idle_mode  = MODE_IDLE;
      idle_start = s;
      idle_sigil = sigil_ff;
      if (!is_space(c)) begin
         idle_start = p;
         if (c == CH_SLASH) begin
            idle_mode = MODE_SLASH;
         end else if (c == CH_MINUS) begin
            idle_mode = MODE_MINUS;
         end else if (c == CH_QUOTE) begin
            idle_mode = MODE_STRING;
         end else if (c == CH_AT || c == CH_PERCENT) begin
            idle_mode  = MODE_SIGIL;
            idle_sigil = (c == CH_PERCENT);
         end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
            idle_mode = MODE_IDENT;
         end else if (is_digit(c)) begin
            idle_mode = MODE_NUM_INT;
         end else if (is_punct(c)) begin
            idle_emit = 1'b1;
         end else begin
            idle_emit = 1'b1;
            idle_rec  = mk_diag(DIAG_UNEXPECTED, p, sat_inc(p));
         end
      end

      if (in_func_ff == FUNC_END) begin
         unique case (mode_ff)
            MODE_SLASH, MODE_MINUS: begin
               pre_rec[0] = mk_diag(DIAG_UNEXPECTED, s, sat_inc(s));
               pre_cnt    = 2'd1;
            end
            MODE_STRING, MODE_STR_ESC: begin
               pre_rec[0] = mk_diag(DIAG_UNTERM, s, p);
               pre_rec[1] = mk_tok(KIND_STRING, s, p);
               pre_cnt    = 2'd2;
            end
            MODE_SIGIL: begin
               pre_rec[0] = mk_diag(DIAG_NONAME, s, sat_inc(s));
               pre_rec[1] = mk_tok(sigil_kind, s, p);
               pre_cnt    = 2'd2;
            end
            MODE_NAME: begin
               pre_rec[0] = mk_tok(sigil_kind, s, p);
               pre_cnt    = 2'd1;
            end
            MODE_IDENT: begin
               pre_rec[0] = mk_tok(KIND_IDENT, s, p);
               pre_cnt    = 2'd1;
            end
            MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_E, MODE_NUM_EXP: begin
               pre_rec[0] = mk_tok(KIND_NUMBER, s, p);
               pre_cnt    = 2'd1;
            end
            default: begin
            end
         endcase
         post_valid = 1'b1;
         post_rec   = mk_tok(KIND_END, p, p);
         // Return to the reset state for the next source.
         mode_in    = MODE_IDLE;
         start_in   = '0;
         pos_in     = '0;
         sigil_in   = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  step_mode = MODE_COMMENT;
               end else begin
                  pre_rec[0] = mk_diag(DIAG_UNEXPECTED, s, sat_inc(s));
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (c == CH_GREATER) begin
                  pre_rec[0] = mk_tok(KIND_ARROW, s, sat_inc(p));
                  pre_cnt    = 2'd1;
                  step_mode  = MODE_IDLE;
               end else if (is_digit(c)) begin
                  step_mode = MODE_NUM_INT;
               end else begin
                  pre_rec[0] = mk_diag(DIAG_UNEXPECTED, s, sat_inc(s));
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  step_mode = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  pre_rec[0] = mk_tok(KIND_STRING, s, sat_inc(p));
                  pre_cnt    = 2'd1;
                  step_mode  = MODE_IDLE;
               end else if (c == CH_BACKSLASH) begin
                  step_mode = MODE_STR_ESC;
               end
            end
            MODE_STR_ESC: begin
               step_mode = MODE_STRING;
            end
            MODE_SIGIL: begin
               if (is_name(c)) begin
                  step_mode = MODE_NAME;
               end else begin
                  pre_rec[0] = mk_diag(DIAG_NONAME, s, sat_inc(s));
                  pre_rec[1] = mk_tok(sigil_kind, s, p);
                  pre_cnt    = 2'd2;
                  redo       = 1'b1;
               end
            end
            MODE_NAME: begin
               if (!is_name(c)) begin
                  pre_rec[0] = mk_tok(sigil_kind, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (!is_name(c)) begin
                  pre_rec[0] = mk_tok(KIND_IDENT, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_NUM_INT: begin
               if (c == CH_DOT) begin
                  step_mode = MODE_NUM_FRAC;
               end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
                  step_mode = MODE_NUM_E;
               end else if (!is_digit(c)) begin
                  pre_rec[0] = mk_tok(KIND_NUMBER, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_NUM_FRAC: begin
               if (c == CH_LOWER_E || c == CH_UPPER_E) begin
                  step_mode = MODE_NUM_E;
               end else if (!is_digit(c)) begin
                  pre_rec[0] = mk_tok(KIND_NUMBER, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_NUM_E: begin
               if (c == CH_PLUS || c == CH_MINUS || is_digit(c)) begin
                  step_mode = MODE_NUM_EXP;
               end else begin
                  pre_rec[0] = mk_tok(KIND_NUMBER, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            MODE_NUM_EXP: begin
               if (!is_digit(c)) begin
                  pre_rec[0] = mk_tok(KIND_NUMBER, s, p);
                  pre_cnt    = 2'd1;
                  redo       = 1'b1;
               end
            end
            default: begin
               redo = 1'b1;
            end
         endcase
         post_valid = redo && idle_emit;
         post_rec   = idle_rec;
         mode_in    = redo ? idle_mode : step_mode;
         start_in   = redo ? idle_start : s;
         sigil_in   = redo ? idle_sigil : sigil_ff;
         pos_in     = sat_inc(p);
      end
   end

   // Pick the record for the current sub-index and run the handshakes.
   always_comb begin
      rec_cnt   = pre_cnt + {1'b0, post_valid};
      sel_rec   = (idx_ff < pre_cnt) ? pre_rec[idx_ff[0]] : post_rec;
      sel_last  = (idx_ff == rec_cnt - 2'd1);
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit_now  = in_valid_ff && (rec_cnt != 2'd0) && out_free;
      retire    = in_valid_ff && ((rec_cnt == 2'd0) || (emit_now && sel_last));
      req_stall = in_valid_ff && !retire;
      accept    = req_valid && !req_stall;
      if (retire) begin
         idx_in = 2'd0;
      end else if (emit_now) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
      if (emit_now) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold control and lexer state; advance state only when a request retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         start_ff     <= '0;
         pos_ff       <= '0;
         sigil_ff     <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (retire) begin
            in_valid_ff <= 1'b0;
         end
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (retire) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            pos_ff   <= pos_in;
            sigil_ff <= sigil_in;
         end
      end
   end

   // Payload registers: load the request on accept, the record on emit.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_byte_value;
      end
      if (emit_now) begin
         rsp_rec_ff  <= sel_rec;
         rsp_last_ff <= sel_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_diagnostic = rsp_rec_ff.is_diag;
   assign rsp_token_kind    = rsp_rec_ff.kind;
   assign rsp_diag_code     = rsp_rec_ff.code;
   assign rsp_span_begin    = rsp_rec_ff.span_begin;
   assign rsp_span_end      = rsp_rec_ff.span_end;
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

`default_nettype wire

>>> verif/ir_text_tokenizer_core_test.sv
`default_nettype none

module ir_text_tokenizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import irtok_pkg::*;

   localparam int POS_BITS = 24;
   // Cycles the response side holds off in one go to back the block up.
   localparam int HOLD_OFF_CYCLES = 64;
   // Requests to send in the whole run, directed part included.
   localparam int TOTAL_REQUESTS = 420;
   // Give up after this many cycles with no handshake on either channel.
   localparam int QUIET_LIMIT = 1000;
   // Extra cycles to watch for stray records once nothing is pending.
   localparam int DRAIN_CYCLES = 16;

   typedef logic [POS_BITS-1:0] pos_type;

   // Lexer states of the prediction; these mirror the block's lex_mode.
   typedef enum logic [3:0] {
      LX_IDLE,
      LX_SLASH,
      LX_COMMENT,
      LX_MINUS,
      LX_STRING,
      LX_STR_ESC,
      LX_SIGIL,
      LX_NAME,
      LX_IDENT,
      LX_INT,
      LX_FRAC,
      LX_EXP_MARK,
      LX_EXP
   } lex_state_type;

   typedef struct packed {
      logic           is_diag;
      token_kind_type kind;
      diag_code_type  code;
      pos_type        span_begin;
      pos_type        span_end;
      logic           last;
   } lex_record_type;

   // Token scoreboard: runs its own copy of the lexer on every accepted request,
   // queues the records that request must produce, and checks each record that
   // leaves the block against the oldest one still queued.
   class token_scoreboard_type;
      lex_record_type expected_records[$];
      lex_record_type fresh[$];
      lex_state_type  mode;
      pos_type        token_start;
      pos_type        position;
      bit             sigil_percent;
      int unsigned    error_count;

      function new();
         clear();
         error_count = 0;
      endfunction

      function void clear();
         mode          = LX_IDLE;
         token_start   = '0;
         position      = '0;
         sigil_percent = 1'b0;
      endfunction

      static function bit is_blank(logic [7:0] c);
         return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
      endfunction

      static function bit is_decimal(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      static function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      static function bit is_name_char(logic [7:0] c);
         return is_letter(c) || is_decimal(c) || c == CH_UNDERSCORE || c == CH_DOT;
      endfunction

      static function bit is_punct_char(logic [7:0] c);
         return c == "{" || c == "}" || c == "[" || c == "]" || c == "(" ||
                c == ")" || c == ":" || c == "," || c == "=";
      endfunction

      // Positions stick at the top instead of wrapping.
      function pos_type bump(pos_type p);
         return (&p) ? p : p + 1'b1;
      endfunction

      function token_kind_type sigil_kind();
         return sigil_percent ? KIND_PERCENT : KIND_AT;
      endfunction

      // Diagnostic records carry a zero kind, token records a zero code.
      function void add_token(token_kind_type k, pos_type b, pos_type e);
         lex_record_type r;
         r = '{is_diag: 1'b0, kind: k, code: DIAG_UNTERM,
               span_begin: b, span_end: e, last: 1'b0};
         if (fresh.size() < 3) fresh = {fresh, r};
      endfunction

      function void add_diag(diag_code_type c, pos_type b, pos_type e);
         lex_record_type r;
         r = '{is_diag: 1'b1, kind: KIND_ARROW, code: c,
               span_begin: b, span_end: e, last: 1'b0};
         if (fresh.size() < 3) fresh = {fresh, r};
      endfunction

      // A byte seen between tokens: skip blanks, open a token or emit a one-byte record.
      function void idle_byte(logic [7:0] c, pos_type p);
         mode = LX_IDLE;
         if (is_blank(c)) return;
         token_start = p;
         if (c == CH_SLASH) mode = LX_SLASH;
         else if (c == CH_MINUS) mode = LX_MINUS;
         else if (c == CH_QUOTE) mode = LX_STRING;
         else if (c == CH_AT || c == CH_PERCENT) begin
            sigil_percent = (c == CH_PERCENT);
            mode = LX_SIGIL;
         end
         else if (is_letter(c) || c == CH_UNDERSCORE) mode = LX_IDENT;
         else if (is_decimal(c)) mode = LX_INT;
         else if (is_punct_char(c)) add_token(KIND_PUNCT, p, bump(p));
         else add_diag(DIAG_UNEXPECTED, p, bump(p));
      endfunction

      // Returning early keeps the byte inside the open token; falling through
      // closes the token and hands the same byte to the idle handling.
      function void take_byte(logic [7:0] c, pos_type p);
         pos_type s;
         s = token_start;
         case (mode)
            LX_SLASH: begin
               if (c == CH_SLASH) begin
                  mode = LX_COMMENT;
                  return;
               end
               add_diag(DIAG_UNEXPECTED, s, bump(s));
            end
            LX_MINUS: begin
               if (c == CH_GREATER) begin
                  add_token(KIND_ARROW, s, bump(p));
                  mode = LX_IDLE;
                  return;
               end
               if (is_decimal(c)) begin
                  mode = LX_INT;
                  return;
               end
               add_diag(DIAG_UNEXPECTED, s, bump(s));
            end
            LX_COMMENT: begin
               if (c == CH_NEWLINE) mode = LX_IDLE;
               return;
            end
            LX_STRING: begin
               if (c == CH_QUOTE) begin
                  add_token(KIND_STRING, s, bump(p));
                  mode = LX_IDLE;
               end
               else if (c == CH_BACKSLASH) mode = LX_STR_ESC;
               return;
            end
            LX_STR_ESC: begin
               mode = LX_STRING;
               return;
            end
            LX_SIGIL: begin
               if (is_name_char(c)) begin
                  mode = LX_NAME;
                  return;
               end
               add_diag(DIAG_NONAME, s, bump(s));
               add_token(sigil_kind(), s, p);
            end
            LX_NAME: begin
               if (is_name_char(c)) return;
               add_token(sigil_kind(), s, p);
            end
            LX_IDENT: begin
               if (is_name_char(c)) return;
               add_token(KIND_IDENT, s, p);
            end
            LX_INT: begin
               if (is_decimal(c)) return;
               if (c == CH_DOT) begin
                  mode = LX_FRAC;
                  return;
               end
               if (c == CH_LOWER_E || c == CH_UPPER_E) begin
                  mode = LX_EXP_MARK;
                  return;
               end
               add_token(KIND_NUMBER, s, p);
            end
            LX_FRAC: begin
               if (is_decimal(c)) return;
               if (c == CH_LOWER_E || c == CH_UPPER_E) begin
                  mode = LX_EXP_MARK;
                  return;
               end
               add_token(KIND_NUMBER, s, p);
            end
            LX_EXP_MARK: begin
               if (c == CH_PLUS || c == CH_MINUS || is_decimal(c)) begin
                  mode = LX_EXP;
                  return;
               end
               add_token(KIND_NUMBER, s, p);
            end
            LX_EXP: begin
               if (is_decimal(c)) return;
               add_token(KIND_NUMBER, s, p);
            end
            default: ;
         endcase
         idle_byte(c, p);
      endfunction

      // End of source: flush whatever is open, then the end token.
      function void take_end(pos_type p);
         pos_type s;
         s = token_start;
         case (mode)
            LX_SLASH, LX_MINUS: add_diag(DIAG_UNEXPECTED, s, bump(s));
            LX_STRING, LX_STR_ESC: begin
               add_diag(DIAG_UNTERM, s, p);
               add_token(KIND_STRING, s, p);
            end
            LX_SIGIL: begin
               add_diag(DIAG_NONAME, s, bump(s));
               add_token(sigil_kind(), s, p);
            end
            LX_NAME: add_token(sigil_kind(), s, p);
            LX_IDENT: add_token(KIND_IDENT, s, p);
            LX_INT, LX_FRAC, LX_EXP_MARK, LX_EXP: add_token(KIND_NUMBER, s, p);
            default: ;
         endcase
         add_token(KIND_END, p, p);
      endfunction

      function void note_request(func_type func, logic [7:0] value);
         pos_type p;
         p = position;
         fresh.delete();
         if (func == FUNC_END) begin
            take_end(p);
            clear();
         end
         else begin
            take_byte(value, p);
            position = bump(p);
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         expected_records = {expected_records, fresh};
      endfunction

      function string describe(lex_record_type r);
         return $sformatf("%s kind=%0d code=%0d span=[%0d,%0d) last=%0b",
                          r.is_diag ? "diag " : "token", r.kind, r.code,
                          r.span_begin, r.span_end, r.last);
      endfunction

      function void check_response(lex_record_type got);
         lex_record_type want;
         if (expected_records.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: record with none pending: %s", $realtime, describe(got));
            return;
         end
         want = expected_records.pop_front();
         if (got.is_diag !== want.is_diag || got.kind !== want.kind ||
             got.code !== want.code || got.span_begin !== want.span_begin ||
             got.span_end !== want.span_end || got.last !== want.last) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: record mismatch\n   expected %s\n   actual   %s",
                        $realtime, describe(want), describe(got));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [7:0]  req_byte_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_diagnostic;
   logic [2:0]  rsp_token_kind;
   logic [1:0]  rsp_diag_code;
   logic [SPAN_BITS-1:0] rsp_span_begin;
   logic [SPAN_BITS-1:0] rsp_span_end;
   logic        rsp_last_of_run;

   token_scoreboard_type tokens = new();

   // Longest idle gap each side may draw before its next request or record;
   // zero gives stretches of back-to-back traffic.
   int gap_limit   = 7;
   int stall_limit = 7;
   // Set by the stimulus to make the response side hold off for a long stretch.
   bit hold_off_pending = 1'b0;
   // Requests accepted so far; paces the random part.
   int sent_requests = 0;

   ir_text_tokenizer_core #(
      .POSITION_BITS(POS_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_diagnostic(rsp_is_diagnostic),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_diag_code    (rsp_diag_code),
      .rsp_span_begin   (rsp_span_begin),
      .rsp_span_end     (rsp_span_end),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   // Offer one request: idle for a random gap, then hold valid and payload until
   // an edge sees stall low. All driving happens right after a rising edge, so
   // the values read there are the ones the block saw at that edge. With a zero
   // gap valid simply stays high and only the payload moves on.
   task automatic offer(func_type func, logic [7:0] value);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_byte_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tokens.note_request(func, value);
      sent_requests++;
   endtask

   task automatic offer_text(string text);
      for (int i = 0; i < text.len(); i++) offer(FUNC_BYTE, text[i]);
   endtask

   function automatic logic [7:0] random_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_name_char();
      case ($urandom_range(0, 3))
         0: return "a" + 8'($urandom_range(0, 25));
         1: return "A" + 8'($urandom_range(0, 25));
         2: return random_digit();
         default: return $urandom_range(0, 1) ? CH_UNDERSCORE : CH_DOT;
      endcase
   endfunction

   function automatic logic [7:0] random_blank();
      int pick;
      pick = $urandom_range(8, 13);
      return (pick == 8) ? CH_SPACE : 8'(pick);
   endfunction

   // Send one token's worth of source: mostly well-formed tokens with random
   // content, plus lone '-' or '/', nameless sigils, open strings and raw noise.
   task automatic random_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) offer_text("->");
      else if (pick < 22) begin
         offer(FUNC_BYTE, CH_QUOTE);
         repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
               0: begin
                  offer(FUNC_BYTE, CH_BACKSLASH);
                  offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
               end
               1: offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
               // printable range below the backslash, quote excluded
               default: offer(FUNC_BYTE, 8'($urandom_range(8'h23, 8'h5B)));
            endcase
         end
         // Leave a few strings open; they swallow what follows up to a quote.
         if ($urandom_range(0, 9) != 0) offer(FUNC_BYTE, CH_QUOTE);
      end
      else if (pick < 32) begin
         offer(FUNC_BYTE, $urandom_range(0, 1) ? CH_PERCENT : CH_AT);
         repeat ($urandom_range(0, 5)) offer(FUNC_BYTE, random_name_char());
      end
      else if (pick < 47) begin
         case ($urandom_range(0, 2))
            0: offer(FUNC_BYTE, CH_UNDERSCORE);
            1: offer(FUNC_BYTE, "A" + 8'($urandom_range(0, 25)));
            default: offer(FUNC_BYTE, "a" + 8'($urandom_range(0, 25)));
         endcase
         repeat ($urandom_range(0, 6)) offer(FUNC_BYTE, random_name_char());
      end
      else if (pick < 65) begin
         if ($urandom_range(0, 2) == 0) offer(FUNC_BYTE, CH_MINUS);
         repeat ($urandom_range(1, 4)) offer(FUNC_BYTE, random_digit());
         if ($urandom_range(0, 1)) begin
            offer(FUNC_BYTE, CH_DOT);
            repeat ($urandom_range(0, 3)) offer(FUNC_BYTE, random_digit());
         end
         if ($urandom_range(0, 2) == 0) begin
            offer(FUNC_BYTE, $urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
            case ($urandom_range(0, 2))
               0: offer(FUNC_BYTE, CH_PLUS);
               1: offer(FUNC_BYTE, CH_MINUS);
               default: ;
            endcase
            repeat ($urandom_range(0, 2)) offer(FUNC_BYTE, random_digit());
         end
      end
      else if (pick < 77) begin
         case ($urandom_range(0, 8))
            0: offer(FUNC_BYTE, "{");
            1: offer(FUNC_BYTE, "}");
            2: offer(FUNC_BYTE, "[");
            3: offer(FUNC_BYTE, "]");
            4: offer(FUNC_BYTE, "(");
            5: offer(FUNC_BYTE, ")");
            6: offer(FUNC_BYTE, ":");
            7: offer(FUNC_BYTE, ",");
            default: offer(FUNC_BYTE, "=");
         endcase
      end
      else if (pick < 82) begin
         offer_text("//");
         repeat ($urandom_range(0, 5)) offer(FUNC_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
         if ($urandom_range(0, 3) != 0) offer(FUNC_BYTE, CH_NEWLINE);
      end
      else if (pick < 90) offer(FUNC_BYTE, $urandom_range(0, 1) ? CH_MINUS : CH_SLASH);
      else offer(FUNC_BYTE, 8'($urandom_range(0, 255)));
   endtask

   // Response side: stall for a random number of cycles (or the long hold-off
   // when asked), then take the next record and check it.
   initial begin : response_side
      lex_record_type got;
      int pause;
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         else begin
            pause = $urandom_range(0, stall_limit);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got.is_diag    = rsp_is_diagnostic;
         got.kind       = token_kind_type'(rsp_token_kind);
         got.code       = diag_code_type'(rsp_diag_code);
         got.span_begin = rsp_span_begin;
         got.span_end   = rsp_span_end;
         got.last       = rsp_last_of_run;
         tokens.check_response(got);
      end
   end

   // Watchdog: count cycles with no handshake on either side; give up at the limit.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("ir_text_tokenizer_core_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= FUNC_BYTE;
      req_byte_value <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed source: arrow, string with an escaped quote, percent name,
      // at-sigil cut off by punctuation, lone slash, identifier ended by a
      // minus, number with fraction and exponent, lone minus, NUL, comment,
      // top byte value, end marker.
      offer_text("->\"\\\"\"%a@,/x-1.e5-");
      offer(FUNC_BYTE, 8'h00);
      offer_text("//\n");
      offer(FUNC_BYTE, 8'hFF);
      offer(FUNC_END, 8'hA5);
      // String whose last character is an escaped quote, still open at the end.
      offer_text("\"\\\"");
      offer(FUNC_END, 8'h5A);

      // Back the block up: punctuation back to back while the response side
      // holds off, so the request side has to stall.
      gap_limit = 0;
      hold_off_pending = 1'b1;
      repeat (3) offer_text("{}[](),:=");
      offer(FUNC_END, 8'h00);
      gap_limit = 7;

      // Random sources, each with its own idling mix, closed by an end marker.
      while (sent_requests < TOTAL_REQUESTS) begin
         gap_limit   = ($urandom_range(0, 3) == 0) ? 0 : 7;
         stall_limit = ($urandom_range(0, 3) == 0) ? 0 : 7;
         repeat ($urandom_range(1, 12)) begin
            if (sent_requests >= TOTAL_REQUESTS) break;
            random_token();
            // blanks are optional so that tokens also end on a foreign byte
            repeat ($urandom_range(0, 2)) offer(FUNC_BYTE, random_blank());
         end
         offer(FUNC_END, 8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray records.
      while (tokens.expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tokens.error_count == 0 && tokens.expected_records.size() == 0)
         $display("ir_text_tokenizer_core_test: PASS");
      else
         $display("ir_text_tokenizer_core_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/irtok_pkg.sv
hw/rtl/ir_text_tokenizer_core.sv
verif/ir_text_tokenizer_core_test.sv
